// File: rtl/slic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_pkg
// Shared constants, register indexes and result type for the sequence logo
// information content block.
// ----------------------------------------------------------------------------
package slic_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ALPHA         = 4;
  localparam int LOG2_ALPHA    = 2;
  localparam int VAL_W         = 32;
  localparam int INFO_W        = 18;
  localparam int CFG_IDX_W     = 3;

  localparam logic [VAL_W-1:0]  BG_RESET = 32'd16384;
  localparam logic [INFO_W-1:0] INFO_MAX = 18'h3FFFF;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_G      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG_T      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PSEUDO    = 3'd5;

  typedef struct packed {
    logic [ALPHA-1:0][VAL_W-1:0] height;
    logic [INFO_W-1:0]           info;
  } result_t;

endpackage

// File: rtl/slic_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_if
// Column, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_a;
  logic [31:0] value_c;
  logic [31:0] value_g;
  logic [31:0] value_t;
  modport source(output valid, value_a, value_c, value_g, value_t, input ready);
  modport sink(input valid, value_a, value_c, value_g, value_t, output ready);
endinterface

interface slic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] height_a;
  logic [31:0] height_c;
  logic [31:0] height_g;
  logic [31:0] height_t;
  logic [17:0] info_content;
  modport source(output valid, height_a, height_c, height_g, height_t, info_content,
                 input ready);
  modport sink(input valid, height_a, height_c, height_g, height_t, info_content,
               output ready);
endinterface

interface slic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/slic_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_div
// Pipelined restoring divider, one quotient bit per stage. Requires
// num < den << QW. A side tag travels with each request.
// ----------------------------------------------------------------------------
module slic_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 48,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [TW-1:0] tag_out
);

  logic          v   [0:QW];
  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [NW-1:0] n   [0:QW];
  logic [DW-1:0] d   [0:QW];
  logic [TW-1:0] tg  [0:QW];

  // load the top numerator bits as the first partial remainder
  assign v[0]   = in_valid;
  assign rem[0] = DW'(num >> QW);
  assign q[0]   = '0;
  assign n[0]   = num;
  assign d[0]   = den;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem[k], n[k][QW-1-k]};
    assign diff  = trial - {1'b0, d[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    // subtract when the trial remainder covers the divisor
    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1]  <= n[k];
        d[k+1]  <= d[k];
        tg[k+1] <= tg[k];
        if (trial >= {1'b0, d[k]}) begin
          rem[k+1] <= diff[DW-1:0];
          q[k+1]   <= q[k] | (QW'(1) << (QW-1-k));
        end else begin
          rem[k+1] <= trial[DW-1:0];
          q[k+1]   <= q[k];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign tag_out   = tg[QW];

endmodule

// File: rtl/slic_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_log
// Pipelined -log2(x / ONE) for 1 <= x <= ONE: leading-one stage, one
// squaring stage per fraction bit, then a final subtract stage.
// ----------------------------------------------------------------------------
module slic_log #(
  parameter int F  = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [F:0]    x,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [F+4:0]  nlog,
  output logic [TW-1:0] tag_out
);

  localparam int EW = $clog2(F + 1);
  localparam int LW = F + 5;

  logic          v    [0:F];
  logic [F:0]    y    [0:F];
  logic [F-1:0]  frac [0:F];
  logic [EW-1:0] e    [0:F];
  logic [TW-1:0] tg   [0:F];

  logic [EW-1:0]  ex;
  logic [2*F:0]   ysh;
  logic [LW-1:0]  ipart;

  // find the leading one and bring x into [ONE, 2*ONE)
  always_comb begin
    ex = '0;
    for (int i = 0; i <= F; i++) begin
      if (x[i]) ex = EW'(i);
    end
    ysh = ((2*F+1)'(x) << F) >> ex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y[0]    <= ysh[F:0];
      frac[0] <= '0;
      e[0]    <= ex;
      tg[0]   <= tag_in;
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_sq
    logic [2*F+1:0] sq;
    logic [F+1:0]   sqs;
    assign sq  = y[j] * y[j];
    assign sqs = sq[2*F+1:F];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    // square, then halve and set the bit when the square reaches two
    always_ff @(posedge clk) begin
      if (en) begin
        e[j+1]  <= e[j];
        tg[j+1] <= tg[j];
        if (sqs[F+1]) begin
          y[j+1]    <= sqs[F+1:1];
          frac[j+1] <= frac[j] | (F'(1) << (F-1-j));
        end else begin
          y[j+1]    <= sqs[F:0];
          frac[j+1] <= frac[j];
        end
      end
    end
  end

  // result is (F - e) << F minus the fraction
  assign ipart = LW'(F) - LW'(e[F]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlog    <= (ipart << F) - LW'(frac[F]);
      tag_out <= tg[F];
    end
  end

endmodule

// File: rtl/sequence_logo_info_content_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_logo_info_content_top
// Letter heights and information content of one DNA motif column.
//
//   channel  | dir | handshake     | payload
//   col_in   | in  | valid / ready | value_a, value_c, value_g, value_t
//   col_out  | out | valid / ready | height_a..height_t, info_content
//   cfg      | in  | valid / ready | index, data (always ready)
//
// One column per cycle while the skid register is empty. The depth is
// set by the three bit-per-stage dividers, the NS = max(1, 2*FRAC_BITS - 27)
// normalizing stages and the squaring log pipeline.
// rst is synchronous and clears all valid bits and the configuration registers.
// A stalled output parks one result in a skid register; the pipeline
// holds only while that register is full.
// ----------------------------------------------------------------------------
module sequence_logo_info_content_top #(
  parameter int FRAC_BITS = slic_pkg::FRAC_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  slic_in_if.sink         col_in,
  slic_out_if.source      col_out,
  slic_cfg_if.sink        cfg
);
  import slic_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int W1  = 33 + F;
  localparam int WS  = W1 + 2;
  localparam int NS  = (2*F - 27 > 0) ? 2*F - 27 : 1;
  localparam int DW2 = 62 - F;
  localparam int QW  = F + 1;
  localparam int NW3 = 33 + F;
  localparam int LW  = F + 5;
  localparam int PW  = F + 6;
  localparam int HW  = F + 8;
  localparam int IW  = F + 2;
  localparam int TW3 = VAL_W + 1;
  localparam int TWL = VAL_W + QW;
  localparam logic [63:0] ONE   = 64'd1 << F;
  localparam logic [63:0] LIMIT = 64'd1 << (62 - F);
  localparam logic [31:0] INFO_BOUND = (2*ONE < 64'h3FFFF) ? 32'(2*ONE) : 32'h3FFFF;

  // configuration registers
  logic             freq_mode;
  logic [VAL_W-1:0] bg [ALPHA];
  logic [VAL_W-1:0] pc;

  logic en;
  logic skid_valid;
  result_t skid;
  result_t od;
  logic ov;

  assign cfg.ready = 1'b1;

  // take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_mode <= 1'b0;
      for (int i = 0; i < ALPHA; i++) bg[i] <= BG_RESET;
      pc <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FREQ_MODE: freq_mode <= cfg.data[0];
        REG_BG_A:      bg[0] <= cfg.data;
        REG_BG_C:      bg[1] <= cfg.data;
        REG_BG_G:      bg[2] <= cfg.data;
        REG_BG_T:      bg[3] <= cfg.data;
        REG_PSEUDO:    pc <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid;
  assign col_in.ready = en;

  // input register
  logic             v1;
  logic [VAL_W-1:0] val1 [ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= col_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1[0] <= col_in.value_a;
      val1[1] <= col_in.value_c;
      val1[2] <= col_in.value_g;
      val1[3] <= col_in.value_t;
    end
  end

  // weight division per letter
  logic             d1v  [ALPHA];
  logic [W1-1:0]    w1   [ALPHA];
  logic [VAL_W-1:0] val2 [ALPHA];

  for (genvar i = 0; i < ALPHA; i++) begin : g_div1
    logic [W1-1:0]    num1;
    logic [VAL_W-1:0] den1;
    assign num1 = W1'({1'b0, val1[i]} + 33'(ONE)) << F;
    assign den1 = (bg[i] != '0) ? bg[i] : 32'd1;
    slic_div #(.NW(W1), .DW(VAL_W), .QW(W1), .TW(VAL_W)) u_div (
      .clk, .rst, .en, .in_valid(v1), .num(num1), .den(den1), .tag_in(val1[i]),
      .out_valid(d1v[i]), .quot(w1[i]), .tag_out(val2[i])
    );
  end

  // shift weights down until the total fits
  logic             vn   [0:NS];
  logic [W1-1:0]    wn   [0:NS][ALPHA];
  logic [VAL_W-1:0] valn [0:NS][ALPHA];

  assign vn[0] = d1v[0];
  for (genvar i = 0; i < ALPHA; i++) begin : g_n0
    assign wn[0][i]   = w1[i];
    assign valn[0][i] = val2[i];
  end

  for (genvar s = 0; s < NS; s++) begin : g_norm
    logic [WS-1:0] sum;
    logic          shift;
    assign sum   = WS'(wn[s][0]) + WS'(wn[s][1]) + WS'(wn[s][2]) + WS'(wn[s][3]);
    assign shift = 64'(sum) >= LIMIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vn[s+1] <= 1'b0;
      end else if (en) begin
        vn[s+1] <= vn[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < ALPHA; i++) begin
          wn[s+1][i]   <= shift ? (wn[s][i] >> 1) : wn[s][i];
          valn[s+1][i] <= valn[s][i];
        end
      end
    end
  end

  // total of the normalized weights
  logic             v3;
  logic [WS-1:0]    tot3;
  logic [W1-1:0]    w3   [ALPHA];
  logic [VAL_W-1:0] val3 [ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vn[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot3 <= WS'(wn[NS][0]) + WS'(wn[NS][1]) + WS'(wn[NS][2]) + WS'(wn[NS][3]);
      for (int i = 0; i < ALPHA; i++) begin
        w3[i]   <= wn[NS][i];
        val3[i] <= valn[NS][i];
      end
    end
  end

  // probability division
  logic            d2v  [ALPHA];
  logic [QW-1:0]   q2   [ALPHA];
  logic [TW3-1:0]  tag2 [ALPHA];

  for (genvar i = 0; i < ALPHA; i++) begin : g_div2
    logic [61:0] num2;
    assign num2 = 62'(w3[i]) << F;
    slic_div #(.NW(62), .DW(DW2), .QW(QW), .TW(TW3)) u_div (
      .clk, .rst, .en, .in_valid(v3), .num(num2), .den(DW2'(tot3)),
      .tag_in({val3[i], tot3 == '0}),
      .out_valid(d2v[i]), .quot(q2[i]), .tag_out(tag2[i])
    );
  end

  // select probabilities by mode
  logic             v4;
  logic [VAL_W-1:0] m4 [ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= d2v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ALPHA; i++) begin
        if (!freq_mode) begin
          m4[i] <= tag2[i][TW3-1:1];
        end else if (tag2[i][0]) begin
          m4[i] <= VAL_W'(ONE >> LOG2_ALPHA);
        end else begin
          m4[i] <= VAL_W'(q2[i]);
        end
      end
    end
  end

  // entropy total with pseudocount
  logic             v5;
  logic [34:0]      tot5;
  logic [VAL_W-1:0] m5 [ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot5 <= 35'(m4[0]) + 35'(m4[1]) + 35'(m4[2]) + 35'(m4[3]) + (35'(pc) << LOG2_ALPHA);
      for (int i = 0; i < ALPHA; i++) m5[i] <= m4[i];
    end
  end

  // renormalize and take the log
  logic             lv   [ALPHA];
  logic [LW-1:0]    nl   [ALPHA];
  logic [TWL-1:0]   tagl [ALPHA];

  for (genvar i = 0; i < ALPHA; i++) begin : g_div3
    logic [NW3-1:0] num3;
    logic           d3v;
    logic [QW-1:0]  q3;
    logic [TW3-1:0] tag3;
    logic [QW-1:0]  r;
    assign num3 = NW3'({1'b0, m5[i]} + {1'b0, pc}) << F;
    slic_div #(.NW(NW3), .DW(35), .QW(QW), .TW(TW3)) u_div (
      .clk, .rst, .en, .in_valid(v5), .num(num3), .den(tot5),
      .tag_in({m5[i], tot5 == '0}),
      .out_valid(d3v), .quot(q3), .tag_out(tag3)
    );
    assign r = tag3[0] ? '0 : q3;
    slic_log #(.F(F), .TW(TWL)) u_log (
      .clk, .rst, .en, .in_valid(d3v), .x(r), .tag_in({tag3[TW3-1:1], r}),
      .out_valid(lv[i]), .nlog(nl[i]), .tag_out(tagl[i])
    );
  end

  // entropy terms
  logic             v6;
  logic [PW-1:0]    p6 [ALPHA];
  logic [VAL_W-1:0] m6 [ALPHA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= lv[0];
    end
  end

  for (genvar i = 0; i < ALPHA; i++) begin : g_term
    logic [2*F+5:0] prod;
    assign prod = tagl[i][QW-1:0] * nl[i];
    always_ff @(posedge clk) begin
      if (en) begin
        p6[i] <= prod[2*F+5:F];
        m6[i] <= tagl[i][TWL-1:QW];
      end
    end
  end

  // entropy and information content
  logic             v7;
  logic [IW-1:0]    info7;
  logic [VAL_W-1:0] m7 [ALPHA];
  logic [HW-1:0]    h;

  assign h = HW'(p6[0]) + HW'(p6[1]) + HW'(p6[2]) + HW'(p6[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info7 <= (64'(h) >= 2*ONE) ? '0 : IW'(2*ONE - 64'(h));
      for (int i = 0; i < ALPHA; i++) m7[i] <= m6[i];
    end
  end

  // letter heights, saturated
  logic    v8;
  result_t td;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  for (genvar i = 0; i < ALPHA; i++) begin : g_height
    logic [VAL_W+IW-1:0] hp;
    assign hp = m7[i] * info7;
    always_ff @(posedge clk) begin
      if (en) begin
        td.height[i] <= (hp[VAL_W+IW-1:F+VAL_W] != '0) ? '1 : hp[F+VAL_W-1:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td.info <= (32'(info7) > 32'(INFO_MAX)) ? INFO_MAX : INFO_W'(info7);
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ov         <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!ov || col_out.ready) begin
      if (skid_valid) begin
        od         <= skid;
        ov         <= 1'b1;
        skid_valid <= 1'b0;
      end else if (v8) begin
        od <= td;
        ov <= 1'b1;
      end else begin
        ov <= 1'b0;
      end
    end else if (en && v8) begin
      skid       <= td;
      skid_valid <= 1'b1;
    end
  end

  assign col_out.valid        = ov;
  assign col_out.height_a     = od.height[0];
  assign col_out.height_c     = od.height[1];
  assign col_out.height_g     = od.height[2];
  assign col_out.height_t     = od.height[3];
  assign col_out.info_content = od.info;

  // letter lanes stay in step
  a_lanes_div1: assert property (@(posedge clk) disable iff (rst)
    d1v[0] == d1v[1] && d1v[0] == d1v[2] && d1v[0] == d1v[3])
    else $error("divider lanes out of step");
  a_lanes_div2: assert property (@(posedge clk) disable iff (rst)
    d2v[0] == d2v[1] && d2v[0] == d2v[2] && d2v[0] == d2v[3])
    else $error("probability lanes out of step");
  a_lanes_log: assert property (@(posedge clk) disable iff (rst)
    lv[0] == lv[1] && lv[0] == lv[2] && lv[0] == lv[3])
    else $error("log lanes out of step");
  // skid fills only behind a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(ov && !col_out.ready))
    else $error("skid filled without stall");
  a_info_bound: assert property (@(posedge clk) disable iff (rst)
    ov |-> 32'(od.info) <= INFO_BOUND)
    else $error("information content out of range");

endmodule
